@@ sv/maf_pkg.sv @@
// -----------------------------------------------------------------------------
// maf_pkg: shared constants for the moving average filter
// Window depth and the widths of samples, sum, fill count and ring index.
// -----------------------------------------------------------------------------
package maf_pkg;

   localparam int DEPTH    = 16;                 // window length, 1..256
   localparam int SAMPLE_W = 32;                 // sample and mean width
   localparam int SUM_W    = 40;                 // running sum, holds 256 * 2^31
   localparam int CNT_W    = $clog2(DEPTH + 1);  // fill count 0..DEPTH
   localparam int POS_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ITER_W   = $clog2(SUM_W);      // divider step counter

endpackage

@@ sv/maf_ram.sv @@
// -----------------------------------------------------------------------------
// maf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// -----------------------------------------------------------------------------
module maf_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/maf_div.sv @@
// -----------------------------------------------------------------------------
// maf_div: iterative signed-by-unsigned divider
// Restoring radix-2 division, one quotient bit per cycle, truncates to zero.
// -----------------------------------------------------------------------------
module maf_div
   import maf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic        [CNT_W-1:0]    divisor,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIX
   } div_state_type;

   div_state_type        state_ff, state_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;       // magnitude in, quotient out
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic                 done_ff, done_in;
   logic [SAMPLE_W-1:0]  res_ff, res_in;

   logic [CNT_W:0]       rem_shift;
   logic [CNT_W+1:0]     diff;
   logic                 fits;
   logic [SUM_W-1:0]     neg_quo;

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
   assign fits      = !diff[CNT_W+1];
   assign neg_quo   = ~quo_ff + SUM_W'(1);

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in   = dividend[SUM_W-1];
               quo_in   = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
               rem_in   = '0;
               dsr_in   = divisor;
               iter_in  = ITER_W'(SUM_W - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in  = fits ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = DIV_FIX;
            end
         end
         DIV_FIX: begin
            res_in   = neg_ff ? neg_quo[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];
            done_in  = 1'b1;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
      res_ff  <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

@@ sv/moving_average_filter.sv @@
// -----------------------------------------------------------------------------
// moving_average_filter: running mean over the last DEPTH signed samples
// Ring buffer, running sum and fill count, with an iterative divider.
// -----------------------------------------------------------------------------
// Each accepted sample yields exactly one result transaction: the mean of the
// samples held (the running sum divided by the fill count, truncated toward
// zero) and a window-full flag. From acceptance until the result is loaded
// into the output register a sample goes through these steps in order: update
// the sum and ring and load the divider, run the 40-bit restoring divider at
// one quotient bit per cycle, fix the sign, take the quotient and load the
// output register. req_tready is high only while no sample is in progress, so
// a new sample is taken only after the previous one has reached the output
// register. A finished result waits in the output register, so the next
// sample may be taken while the previous result is still pending; that sample
// then waits before its own result can be loaded.
// -----------------------------------------------------------------------------
module moving_average_filter
   import maf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] sample (signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] mean (signed)
   output logic        rsp_tuser     // [0] window_full
);

   typedef enum logic [1:0] {
      ST_IDLE,     // waiting for a sample
      ST_UPDATE,   // displaced sample is read, update sum and ring
      ST_DIVIDE,   // divider busy
      ST_DELIVER   // mean ready, waiting for the output register
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic        [POS_W-1:0]     pos_ff, pos_in;
   logic        [CNT_W-1:0]     count_ff, count_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic                        full_ff, full_in;      // flag for the item in flight
   logic                        rsp_valid_ff, rsp_valid_in;
   logic        [SAMPLE_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic                        rsp_full_ff, rsp_full_in;
   logic        [SAMPLE_W-1:0]  mean_ff, mean_in;

   logic                        req_take;
   logic                        window_was_full;
   logic signed [SAMPLE_W-1:0]  old_sample;
   logic signed [SUM_W-1:0]     old_term;
   logic                        ram_wr_en;
   logic                        div_start;
   logic                        div_done;
   logic signed [SAMPLE_W-1:0]  div_quotient;

   assign req_tready      = (state_ff == ST_IDLE);
   assign req_take        = req_tvalid && req_tready;
   assign window_was_full = (count_ff == CNT_W'(DEPTH));
   assign old_term        = window_was_full ? SUM_W'(old_sample) : '0;
   assign ram_wr_en       = (state_ff == ST_UPDATE);
   assign div_start       = (state_ff == ST_UPDATE);

   // Ring of held samples; the entry at the write position is read on
   // acceptance and overwritten in the following cycle.
   maf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (pos_ff),
      .rd_data (old_sample)
   );

   // Sum over count, one quotient bit a cycle
   maf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_full_in  = rsp_full_ff;
      mean_in      = mean_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_tdata;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // add the new sample, drop the displaced one once the window is full
            sum_in   = sum_ff + SUM_W'(sample_ff) - old_term;
            count_in = window_was_full ? count_ff : count_ff + CNT_W'(1);
            full_in  = window_was_full || (count_ff == CNT_W'(DEPTH - 1));
            pos_in   = (pos_ff == POS_W'(DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = div_quotient;
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_full_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      full_ff     <= full_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_full_ff <= rsp_full_in;
      mean_ff     <= mean_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mean_ff;
   assign rsp_tuser  = rsp_full_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for moving_average_filter
// Sends a short table of directed samples and then about 1450 random ones
// through the request stream. Every transaction is run through a local copy
// of the ring, count and sum. Each response is checked in order against what
// that copy predicts, or against the hand-written expectation of a pinned row.
// Both streams stall at random, except for one long stretch where neither side idles.
// -----------------------------------------------------------------------------
module tb;
   import maf_pkg::*;

   localparam int N_DIRECTED   = 25;
   localparam int RANDOM_ITEMS = 1450;
   localparam int STILL_LIMIT  = 4000;   // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_PRINTS   = 40;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic                full;
   } avg_result_type;

   // one directed row; pinned rows carry a hand-written expectation
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                pinned;
      logic [SAMPLE_W-1:0] mean;
      logic                full;
   } stim_row_type;

   typedef enum int {MIX_FULL_RANGE, MIX_EXTREMES, MIX_SMALL, MIX_HOLD} sample_mix_type;

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},   // most negative, first after reset
      '{32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},           // negative sum, truncation toward zero
      '{32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
      '{32'h5555_5555, 1'b0, 32'h0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFD, 1'b0, 32'h0, 1'b0},
      '{32'h1234_5678, 1'b0, 32'h0, 1'b0},
      '{32'hEDCB_A988, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},           // window becomes full
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},           // replaces oldest (most negative)
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] sample (signed)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] mean (signed)
   logic        rsp_tuser;    // [0] window_full

   moving_average_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // local window: ring, write position, fill count and running sum
   logic signed [SAMPLE_W-1:0] window_ring [DEPTH] = '{default: '0};
   logic [POS_W-1:0]           head_pos   = '0;
   logic [CNT_W-1:0]           held_count = '0;
   logic signed [SUM_W-1:0]    window_sum = '0;

   stim_row_type   sent_rows[$];      // rows offered, oldest first
   avg_result_type pending_means[$];  // expected responses, oldest first

   logic no_idle;                     // set during the stretch without stalls
   int   error_count   = 0;
   int   samples_taken = 0;
   int   means_seen    = 0;
   int   full_seen     = 0;
   int   still_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Push one sample into the local window and return the mean it gives.
   function automatic avg_result_type advance_window(
      input logic signed [SAMPLE_W-1:0] sample);
      logic signed [SUM_W-1:0] divisor;
      logic signed [SUM_W-1:0] quotient;
      avg_result_type          r;
      if (held_count < DEPTH) begin
         held_count = held_count + 1'b1;
         window_sum = window_sum + sample;
      end else begin
         window_sum = window_sum - window_ring[head_pos] + sample;
      end
      window_ring[head_pos] = sample;
      if (head_pos == POS_W'(DEPTH - 1))
         head_pos = '0;
      else
         head_pos = head_pos + 1'b1;
      divisor  = held_count;           // zero-extended, count is never zero here
      quotient = window_sum / divisor; // signed, truncates toward zero
      r.mean   = quotient[SAMPLE_W-1:0];
      r.full   = (held_count == DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (error_count < MAX_PRINTS)
         $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   // Offer one sample; valid drops on random cycles while waiting.
   // Returns at the rising edge where the sample is taken.
   task automatic send_sample(input stim_row_type row);
      sent_rows.push_back(row);
      do begin
         @(negedge clock);
         req_tvalid <= no_idle || ($urandom_range(0, 99) >= 21);
         req_tdata  <= row.sample;
         @(posedge clock);
      end while (!(req_tvalid && req_tready));
   endtask

   // Response side: mostly single-cycle stalls, now and then a long one that
   // lets a finished mean sit in the output register while the next is computed.
   initial begin : rsp_stalls
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 99) == 0) ? $urandom_range(50, 60) : 0;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Transaction monitor: predict on the request side, check on the response side.
   always @(posedge clock) begin : monitor
      stim_row_type   row;
      avg_result_type predicted;
      avg_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            row       = sent_rows.pop_front();
            predicted = advance_window(req_tdata);
            if (row.pinned)
               pending_means.push_back(avg_result_type'{row.mean, row.full});
            else
               pending_means.push_back(predicted);
            samples_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            means_seen++;
            if (rsp_tuser)
               full_seen++;
            if (pending_means.size() == 0) begin
               report_mismatch("response with nothing outstanding", 32'h0, rsp_tdata);
            end else begin
               want = pending_means.pop_front();
               if (rsp_tdata !== want.mean)
                  report_mismatch("mean", want.mean, rsp_tdata);
               if (rsp_tuser !== want.full)
                  report_mismatch("window_full", {31'h0, want.full}, {31'h0, rsp_tuser});
            end
         end
      end
   end

   // Watchdog on stretches without any transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         still_cycles <= 0;
      end else if (still_cycles >= STILL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STILL_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         still_cycles <= still_cycles + 1;
      end
   end

   initial begin : stimulus
      int             run_left;
      sample_mix_type mix;
      logic [31:0]    level;
      logic [31:0]    s;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      no_idle    = 1'b0;
      run_left   = 0;
      mix        = MIX_FULL_RANGE;
      level      = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_sample(DIRECTED[i]);

      // runs of one flavour so the window fills with extremes, constants, etc.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 600 && n < 900);
         if (run_left == 0) begin
            mix      = sample_mix_type'($urandom_range(0, 3));
            run_left = $urandom_range(1, 40);
            level    = $urandom;
         end
         run_left--;
         case (mix)
            MIX_FULL_RANGE: s = $urandom;
            MIX_EXTREMES:   s = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 2)
                                                     : 32'h8000_0000 + $urandom_range(0, 2);
            MIX_SMALL:      s = 32'($urandom_range(0, 64)) - 32'd32;
            default:        s = level;
         endcase
         send_sample('{s, 1'b0, 32'h0, 1'b0});
      end
      no_idle = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent (%0d directed), %0d means checked, %0d with full window",
               samples_taken, N_DIRECTED, means_seen, full_seen);
      $display("%0d mismatches", error_count);
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
sv/maf_pkg.sv
sv/maf_ram.sv
sv/maf_div.sv
sv/moving_average_filter.sv
tb/tb.sv
